// File: src/cbps_pkg.sv
// shared constants, types and helpers of the bezier polyline smoother
`default_nettype none
package cbps_pkg;

    localparam int MAX_SUB     = 64;
    localparam int NCOMP       = 8;
    localparam int CW          = 24;
    localparam int PW          = CW + 1;
    localparam int CFG_W       = 7;
    localparam int N_W         = $clog2(MAX_SUB + 1);
    localparam int K_W         = $clog2(MAX_SUB);
    localparam int N2_W        = $clog2(MAX_SUB * MAX_SUB + 1);
    localparam int N3_W        = $clog2(MAX_SUB * MAX_SUB * MAX_SUB + 1);
    localparam int D_W         = N3_W + 1;
    localparam int NUM_W       = N3_W + PW;
    localparam int NTERM       = 4;
    localparam int DIV_BITS    = 2;
    localparam int DIV_STEPS   = CW / DIV_BITS;
    localparam int DC_W        = $clog2(DIV_STEPS);

    localparam int COMP_X = 0;
    localparam int COMP_Y = 1;
    localparam int COMP_Z = 2;
    localparam int COMP_R = 3;
    localparam int COMP_G = 4;
    localparam int COMP_B = 5;
    localparam int COMP_U = 6;
    localparam int COMP_V = 7;

    localparam logic [CFG_W-1:0] SUBDIV_RESET = CFG_W'(16);

    typedef logic [NCOMP-1:0][CW-1:0] t_vec;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CUBE,
        ST_WGT1,
        ST_WGT2,
        ST_PROD,
        ST_SUM,
        ST_DIV,
        ST_EMIT,
        ST_FLAT
    } t_state;

    typedef struct packed {
        logic start_in;
        logic load_in;
        logic seg_init;
        logic seg_cube;
        logic wgt1;
        logic wgt2;
        logic prod;
        logic sum;
        logic div_step;
        logic emit_curve;
        logic emit_flat;
        logic k_next;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic have_prev;
        logic z_equal;
        logic div_last;
        logic k_last;
        logic out_free;
    } t_status;

    // subdivision count forced into 1..MAX_SUB
    function automatic logic [N_W-1:0] clamp_sub(input logic [CFG_W-1:0] v);
        logic [N_W-1:0] res;
        if (v == '0) begin
            res = N_W'(1);
        end else if (32'(v) > MAX_SUB) begin
            res = N_W'(MAX_SUB);
        end else begin
            res = N_W'(v);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: src/cbps_if.sv
// vertex and point word channels of the bezier polyline smoother
`default_nettype none
interface cbps_vtx_if;
    import cbps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic signed [CW-1:0] col_r;
    logic signed [CW-1:0] col_g;
    logic signed [CW-1:0] col_b;
    logic signed [CW-1:0] tex_u;
    logic signed [CW-1:0] tex_v;
    logic                 curve_start;

    modport source (
        output valid, pos_x, pos_y, pos_z, col_r, col_g, col_b, tex_u, tex_v, curve_start,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, col_r, col_g, col_b, tex_u, tex_v, curve_start,
        output ready
    );
endinterface

interface cbps_pt_if;
    import cbps_pkg::*;

    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic signed [CW-1:0] out_z;
    logic signed [CW-1:0] out_r;
    logic signed [CW-1:0] out_g;
    logic signed [CW-1:0] out_b;
    logic signed [CW-1:0] out_u;
    logic signed [CW-1:0] out_v;
    logic                 run_last;

    modport source (
        output valid, out_x, out_y, out_z, out_r, out_g, out_b, out_u, out_v, run_last,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, out_r, out_g, out_b, out_u, out_v, run_last,
        output ready
    );
endinterface
`default_nettype wire

// File: src/cbps_ctrl.sv
// sequencing state machine of the bezier polyline smoother
`default_nettype none
module cbps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_start,
    output logic              o_in_ready,
    input  cbps_pkg::t_status i_status,
    output cbps_pkg::t_cmd    o_cmd
);
    import cbps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_start || !i_status.have_prev) begin
                        o_cmd.start_in = 1'b1;
                    end else begin
                        o_cmd.load_in = 1'b1;
                        n_state       = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                o_cmd.seg_init = 1'b1;
                n_state        = i_status.z_equal ? ST_FLAT : ST_CUBE;
            end
            ST_CUBE: begin
                o_cmd.seg_cube = 1'b1;
                n_state        = ST_WGT1;
            end
            ST_WGT1: begin
                o_cmd.wgt1 = 1'b1;
                n_state    = ST_WGT2;
            end
            ST_WGT2: begin
                o_cmd.wgt2 = 1'b1;
                n_state    = ST_PROD;
            end
            ST_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_curve = 1'b1;
                    if (i_status.k_last) begin
                        o_cmd.commit = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        o_cmd.k_next = 1'b1;
                        n_state      = ST_WGT1;
                    end
                end
            end
            ST_FLAT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_flat = 1'b1;
                    o_cmd.commit    = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/cbps_dp.sv
// datapath of the bezier polyline smoother: weights, products, divider lanes
`default_nettype none
module cbps_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cbps_pkg::t_cmd            i_cmd,
    output cbps_pkg::t_status         o_status,
    input  cbps_pkg::t_vec            i_vtx_data,
    input  logic                      i_cfg_we,
    input  logic [cbps_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output cbps_pkg::t_vec            o_out_data,
    output logic                      o_out_last
);
    import cbps_pkg::*;

    logic [CFG_W-1:0]    r_subdiv;
    logic                r_have_prev;
    t_vec                r_prev;
    t_vec                r_cur;
    logic [N_W-1:0]      r_n;
    logic [N2_W-1:0]     r_n2;
    logic [N3_W-1:0]     r_n3;
    logic [K_W-1:0]      r_k;
    logic [N2_W-1:0]     r_a2;
    logic [N2_W-1:0]     r_k2;
    logic [N2_W-1:0]     r_ka;
    logic [NTERM-1:0][N3_W-1:0] r_w;
    logic [NUM_W-1:0]    r_prod [NCOMP][NTERM];
    logic [D_W-1:0]      r_rem  [NCOMP];
    logic [CW-1:0]       r_dq   [NCOMP];
    logic [DC_W-1:0]     r_dc;
    logic                r_out_valid;
    t_vec                r_out_data;
    logic                r_out_last;

    logic [N_W-1:0]      n_clamped;
    logic [N_W-1:0]      a_val;
    logic [D_W-1:0]      div_d;
    logic [N3_W+1:0]     kaa;
    logic [N3_W+1:0]     kak;
    logic [NCOMP-1:0][NTERM-1:0][PW-1:0] cp;
    logic [NCOMP-1:0][NUM_W-1:0] sum;
    logic [D_W-1:0]      n_rem [NCOMP];
    logic [CW-1:0]       n_dq  [NCOMP];
    logic [CW-1:0]       off0;
    logic [CW-1:0]       off1;
    logic [D_W:0]        trial;
    logic [D_W-1:0]      rem_t;
    logic [CW-1:0]       dq_t;

    assign n_clamped = clamp_sub(r_subdiv);
    assign a_val     = r_n - N_W'(r_k);
    assign div_d     = {r_n3, 1'b0};
    assign kaa       = (N3_W + 2)'(r_ka) * (N3_W + 2)'(a_val);
    assign kak       = (N3_W + 2)'(r_ka) * (N3_W + 2)'(r_k);

    assign o_status.have_prev = r_have_prev;
    assign o_status.z_equal   = (r_cur[COMP_Z] == r_prev[COMP_Z]);
    assign o_status.div_last  = (r_dc == DC_W'(DIV_STEPS - 1));
    assign o_status.k_last    = ((N_W'(r_k) + N_W'(1)) == r_n);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

    // control points at twice the scale, offset to stay non-negative
    always_comb begin
        for (int f = 0; f < NCOMP; f++) begin
            off0     = {~r_prev[f][CW-1], r_prev[f][CW-2:0]};
            off1     = {~r_cur[f][CW-1], r_cur[f][CW-2:0]};
            cp[f][0] = {off0, 1'b0};
            cp[f][1] = {off0, 1'b0};
            cp[f][2] = {off1, 1'b0};
            cp[f][3] = {off1, 1'b0};
            if (f == COMP_Y) begin
                cp[f][1] = PW'(off0) + PW'(off1);
                cp[f][2] = PW'(off0) + PW'(off1);
            end else if (f == COMP_V) begin
                cp[f][1] = PW'(off0) + (PW'(1) << (CW - 1));
            end
        end
    end

    // numerator plus half the divisor for rounding
    always_comb begin
        for (int f = 0; f < NCOMP; f++) begin
            sum[f] = r_prod[f][0] + r_prod[f][1] + r_prod[f][2] + r_prod[f][3]
                   + NUM_W'(r_n3);
        end
    end

    // two restoring division bits per lane and cycle
    always_comb begin
        for (int f = 0; f < NCOMP; f++) begin
            rem_t = r_rem[f];
            dq_t  = r_dq[f];
            for (int b = 0; b < DIV_BITS; b++) begin
                trial = {rem_t, dq_t[CW-1]};
                if (trial >= {1'b0, div_d}) begin
                    rem_t = D_W'(trial - {1'b0, div_d});
                    dq_t  = {dq_t[CW-2:0], 1'b1};
                end else begin
                    rem_t = trial[D_W-1:0];
                    dq_t  = {dq_t[CW-2:0], 1'b0};
                end
            end
            n_rem[f] = rem_t;
            n_dq[f]  = dq_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subdiv    <= SUBDIV_RESET;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_subdiv <= i_cfg_data;
            end
            if (i_cmd.start_in) begin
                r_have_prev <= 1'b1;
            end
            if (i_cmd.emit_curve || i_cmd.emit_flat) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_in) begin
            r_prev <= i_vtx_data;
        end else if (i_cmd.commit) begin
            r_prev <= r_cur;
        end
        if (i_cmd.load_in) begin
            r_cur <= i_vtx_data;
        end
        if (i_cmd.seg_init) begin
            r_n  <= n_clamped;
            r_n2 <= N2_W'(n_clamped) * N2_W'(n_clamped);
            r_k  <= '0;
        end
        if (i_cmd.seg_cube) begin
            r_n3 <= N3_W'(r_n2) * N3_W'(r_n);
        end
        if (i_cmd.k_next) begin
            r_k <= r_k + K_W'(1);
        end
        if (i_cmd.wgt1) begin
            r_a2 <= N2_W'(a_val) * N2_W'(a_val);
            r_k2 <= N2_W'(r_k) * N2_W'(r_k);
            r_ka <= N2_W'(r_k) * N2_W'(a_val);
        end
        if (i_cmd.wgt2) begin
            r_w[0] <= N3_W'(r_a2) * N3_W'(a_val);
            r_w[1] <= N3_W'(kaa + (kaa << 1));
            r_w[2] <= N3_W'(kak + (kak << 1));
            r_w[3] <= N3_W'(r_k2) * N3_W'(r_k);
        end
        if (i_cmd.prod) begin
            for (int f = 0; f < NCOMP; f++) begin
                for (int j = 0; j < NTERM; j++) begin
                    r_prod[f][j] <= NUM_W'(r_w[j]) * NUM_W'(cp[f][j]);
                end
            end
        end
        if (i_cmd.sum) begin
            r_dc <= '0;
            for (int f = 0; f < NCOMP; f++) begin
                r_rem[f] <= sum[f][NUM_W-1:CW];
                r_dq[f]  <= sum[f][CW-1:0];
            end
        end else if (i_cmd.div_step) begin
            r_dc <= r_dc + DC_W'(1);
            for (int f = 0; f < NCOMP; f++) begin
                r_rem[f] <= n_rem[f];
                r_dq[f]  <= n_dq[f];
            end
        end
        if (i_cmd.emit_curve) begin
            for (int f = 0; f < NCOMP; f++) begin
                r_out_data[f] <= {~r_dq[f][CW-1], r_dq[f][CW-2:0]};
            end
            r_out_last <= o_status.k_last;
        end else if (i_cmd.emit_flat) begin
            r_out_data <= r_prev;
            r_out_last <= 1'b1;
        end
    end

endmodule
`default_nettype wire

// File: src/cubic_bezier_polyline_smoother_core.sv
// top level of the cubic bezier polyline smoother
`default_nettype none
// Vertices come in one word at a time; each one ends the segment from the
// stored vertex. A start vertex, or the first one after reset, is only
// stored. A segment with equal z values gives the stored vertex once. A
// curved segment gives N points, N = subdivisions clamped to 1..64, through
// the accept, check and cube states, then for each point the weight states
// WGT1 and WGT2, the product and sum states, the division steps of the eight
// radix-4 divider lanes and the load into the output register. A point that
// is ready while the output register still holds an untaken point waits in
// the emit state. The next vertex is taken once the last point sits in the
// output register. The user must write the subdivisions register only while
// the block is idle; the block itself does not enforce this.
module cubic_bezier_polyline_smoother_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cbps_pkg::CFG_W-1:0] i_cfg_data,
    cbps_vtx_if.sink                   i_vtx,
    cbps_pt_if.source                  o_pt
);
    import cbps_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_vec    vtx_data;
    t_vec    out_data;
    logic    out_last;
    logic    out_valid;

    assign vtx_data[COMP_X] = i_vtx.pos_x;
    assign vtx_data[COMP_Y] = i_vtx.pos_y;
    assign vtx_data[COMP_Z] = i_vtx.pos_z;
    assign vtx_data[COMP_R] = i_vtx.col_r;
    assign vtx_data[COMP_G] = i_vtx.col_g;
    assign vtx_data[COMP_B] = i_vtx.col_b;
    assign vtx_data[COMP_U] = i_vtx.tex_u;
    assign vtx_data[COMP_V] = i_vtx.tex_v;

    cbps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_vtx.valid),
        .i_in_start (i_vtx.curve_start),
        .o_in_ready (i_vtx.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cbps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_vtx_data  (vtx_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_pt.ready),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .o_out_last  (out_last)
    );

    assign o_pt.valid    = out_valid;
    assign o_pt.out_x    = out_data[COMP_X];
    assign o_pt.out_y    = out_data[COMP_Y];
    assign o_pt.out_z    = out_data[COMP_Z];
    assign o_pt.out_r    = out_data[COMP_R];
    assign o_pt.out_g    = out_data[COMP_G];
    assign o_pt.out_b    = out_data[COMP_B];
    assign o_pt.out_u    = out_data[COMP_U];
    assign o_pt.out_v    = out_data[COMP_V];
    assign o_pt.run_last = out_last;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for the cubic bezier polyline smoother core
`default_nettype none
module tb_top;
    import cbps_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int NPH          = 8;
    localparam int MAX_PRINT    = 30;
    localparam logic [CW-1:0] VAL_MAX = 24'h7FFFFF;
    localparam logic [CW-1:0] VAL_MIN = 24'h800000;

    typedef struct packed {
        t_vec comp;
        logic start;
        logic wait_drain;
    } t_vtx_word;

    typedef struct packed {
        t_vec comp;
        logic last;
    } t_pt_word;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_W-1:0]     cfg_data;

    cbps_vtx_if vtx ();
    cbps_pt_if  pt ();

    cubic_bezier_polyline_smoother_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_vtx      (vtx),
        .o_pt       (pt)
    );

    t_vtx_word        pend_vtx [$];
    t_pt_word         exp_pts [$];
    t_vtx_word        cur_vtx;
    t_vec             prev_vtx;
    logic             have_prev;
    logic [CFG_W-1:0] subdiv_reg;
    logic [CW-1:0]    last_z;
    int               idle_src_pct;
    int               idle_snk_pct;
    int               n_popped;
    int               n_taken;
    int               n_points;
    int               n_curves;
    int               n_flats;
    int               n_errors;
    int               n_settings;
    int               cycles;

    int ph_src [NPH] = '{15, 15, 15, 77, 77, 0, 0, 0};
    int ph_snk [NPH] = '{77, 77, 77, 15, 15, 0, 0, 0};
    int ph_cfg [NPH] = '{0, 3, 64, 1, 127, 5, 2, 100};
    int ph_cnt [NPH] = '{25, 25, 4, 25, 3, 30, 30, 4};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int eff_subdiv(input logic [CFG_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 1) begin
            n = 1;
        end else if (n > MAX_SUB) begin
            n = MAX_SUB;
        end
        return n;
    endfunction

    // one component of the bezier point, numerators at twice the scale
    function automatic logic [CW-1:0] bez_comp(input int f, input longint k, input longint n,
                                               input logic [CW-1:0] a, input logic [CW-1:0] b);
        longint s0, s1, p0, p1, c1, c2, w, w0, w1, w2, w3, num, d, r;
        s0 = $signed(a);
        s1 = $signed(b);
        p0 = 2 * s0 + 64'sd16777216;
        p1 = 2 * s1 + 64'sd16777216;
        c1 = p1;
        c2 = p0;
        if (f == COMP_Y) begin
            c1 = s0 + s1 + 64'sd16777216;
            c2 = c1;
        end else if (f == COMP_V) begin
            c2 = s0 + 64'sd16777216;
        end
        w   = n - k;
        w0  = w * w * w;
        w1  = 3 * k * w * w;
        w2  = 3 * k * k * w;
        w3  = k * k * k;
        num = w0 * p0 + w1 * c2 + w2 * c1 + w3 * p1;
        d   = 2 * n * n * n;
        r   = (num + d / 2) / d;
        return CW'(r) ^ VAL_MIN;
    endfunction

    task automatic predict_points(input t_vtx_word w);
        t_pt_word p;
        int       n;
        if (w.start || !have_prev) begin
            have_prev = 1'b1;
        end else if (w.comp[COMP_Z] == prev_vtx[COMP_Z]) begin
            p.comp = prev_vtx;
            p.last = 1'b1;
            exp_pts = {exp_pts, p};
            n_flats++;
        end else begin
            n = eff_subdiv(subdiv_reg);
            for (int k = 0; k < n; k++) begin
                for (int f = 0; f < NCOMP; f++) begin
                    p.comp[f] = bez_comp(f, k, n, prev_vtx[f], w.comp[f]);
                end
                p.last = (k == n - 1);
                exp_pts = {exp_pts, p};
            end
            n_curves++;
        end
        prev_vtx = w.comp;
    endtask

    task automatic report(input string what, input logic [CW-1:0] want, input logic [CW-1:0] got);
        n_errors++;
        if (n_errors <= MAX_PRINT) begin
            $display("error at cycle %0d: %s expected %h got %h", cycles, what, want, got);
        end
    endtask

    task automatic check_point();
        t_pt_word want;
        t_vec     got;
        got[COMP_X] = pt.out_x;
        got[COMP_Y] = pt.out_y;
        got[COMP_Z] = pt.out_z;
        got[COMP_R] = pt.out_r;
        got[COMP_G] = pt.out_g;
        got[COMP_B] = pt.out_b;
        got[COMP_U] = pt.out_u;
        got[COMP_V] = pt.out_v;
        if (exp_pts.size() == 0) begin
            report("point word with none expected, x", '0, got[COMP_X]);
        end else begin
            want = exp_pts.pop_front();
            n_points++;
            for (int f = 0; f < NCOMP; f++) begin
                if (got[f] !== want.comp[f]) begin
                    report($sformatf("point %0d component %0d", n_points, f),
                           want.comp[f], got[f]);
                end
            end
            if (pt.run_last !== want.last) begin
                report($sformatf("point %0d run_last", n_points), CW'(want.last), CW'(pt.run_last));
            end
        end
    endtask

    // vertex word driver
    always @(posedge clk) begin : drv
        logic go;
        if (!rst_n) begin
            vtx.valid       <= 1'b0;
            vtx.pos_x       <= '0;
            vtx.pos_y       <= '0;
            vtx.pos_z       <= '0;
            vtx.col_r       <= '0;
            vtx.col_g       <= '0;
            vtx.col_b       <= '0;
            vtx.tex_u       <= '0;
            vtx.tex_v       <= '0;
            vtx.curve_start <= 1'b0;
        end else begin
            if (vtx.valid && vtx.ready) begin
                predict_points(cur_vtx);
                n_taken++;
            end
            if (!vtx.valid || vtx.ready) begin
                go = (pend_vtx.size() != 0) && ($urandom_range(0, 99) >= idle_src_pct);
                if (go && pend_vtx[0].wait_drain && exp_pts.size() != 0) begin
                    go = 1'b0;
                end
                if (go) begin
                    cur_vtx = pend_vtx.pop_front();
                    n_popped++;
                    vtx.pos_x       <= cur_vtx.comp[COMP_X];
                    vtx.pos_y       <= cur_vtx.comp[COMP_Y];
                    vtx.pos_z       <= cur_vtx.comp[COMP_Z];
                    vtx.col_r       <= cur_vtx.comp[COMP_R];
                    vtx.col_g       <= cur_vtx.comp[COMP_G];
                    vtx.col_b       <= cur_vtx.comp[COMP_B];
                    vtx.tex_u       <= cur_vtx.comp[COMP_U];
                    vtx.tex_v       <= cur_vtx.comp[COMP_V];
                    vtx.curve_start <= cur_vtx.start;
                    vtx.valid       <= 1'b1;
                end else begin
                    vtx.valid <= 1'b0;
                end
            end
        end
    end

    // point word monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            pt.ready <= 1'b0;
        end else begin
            if (pt.valid && pt.ready) begin
                check_point();
            end
            pt.ready <= ($urandom_range(0, 99) >= idle_snk_pct);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("cubic_bezier_polyline_smoother_core: mismatch");
            $finish;
        end
    end

    function automatic logic [CW-1:0] rand_comp();
        logic [CW-1:0] v;
        case ($urandom_range(0, 7))
            0: begin
                v = VAL_MAX;
            end
            1: begin
                v = VAL_MIN;
            end
            2: begin
                v = CW'($urandom_range(0, 511)) - CW'(256);
            end
            default: begin
                v = CW'($urandom());
            end
        endcase
        return v;
    endfunction

    function automatic t_vtx_word rand_word(input logic st);
        t_vtx_word w;
        for (int f = 0; f < NCOMP; f++) begin
            w.comp[f] = rand_comp();
        end
        w.start      = st;
        w.wait_drain = 1'b0;
        return w;
    endfunction

    function automatic t_vtx_word fill_word(input logic [CW-1:0] v, input logic st);
        t_vtx_word w;
        for (int f = 0; f < NCOMP; f++) begin
            w.comp[f] = v;
        end
        w.start      = st;
        w.wait_drain = 1'b0;
        return w;
    endfunction

    task automatic push_word(input t_vtx_word w);
        last_z = w.comp[COMP_Z];
        pend_vtx = {pend_vtx, w};
    endtask

    task automatic wait_idle();
        while (pend_vtx.size() != 0 || n_popped != n_taken || exp_pts.size() != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    initial begin
        t_vtx_word w;
        int        r;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        prev_vtx        = '0;
        have_prev       = 1'b0;
        subdiv_reg      = SUBDIV_RESET;
        last_z          = '0;
        idle_src_pct    = ph_src[0];
        idle_snk_pct    = ph_snk[0];
        n_popped        = 0;
        n_taken         = 0;
        n_points        = 0;
        n_curves        = 0;
        n_flats         = 0;
        n_errors        = 0;
        n_settings      = 1;
        cycles          = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // first vertex without start flag, then full-scale curves and flats
        push_word(fill_word(VAL_MIN, 1'b0));
        push_word(fill_word(VAL_MAX, 1'b0));
        push_word(fill_word(VAL_MIN, 1'b0));
        w = fill_word(VAL_MAX, 1'b0);
        w.comp[COMP_Z] = VAL_MIN;
        push_word(w);
        push_word(rand_word(1'b1));
        w = rand_word(1'b0);
        w.wait_drain = 1'b1;
        push_word(w);
        w = rand_word(1'b0);
        w.comp[COMP_Z] = last_z;
        push_word(w);
        push_word(fill_word('0, 1'b1));
        push_word(rand_word(1'b0));
        push_word(fill_word(VAL_MAX, 1'b0));
        w = rand_word(1'b0);
        w.comp[COMP_Z] = last_z;
        push_word(w);
        w = rand_word(1'b0);
        w.comp[COMP_Y] = VAL_MAX;
        w.comp[COMP_V] = VAL_MIN;
        push_word(w);
        w = rand_word(1'b0);
        w.comp[COMP_Y] = VAL_MIN;
        w.comp[COMP_V] = VAL_MAX;
        push_word(w);
        push_word(rand_word(1'b0));

        for (int ph = 0; ph < NPH; ph++) begin
            wait_idle();
            idle_src_pct = ph_src[ph];
            idle_snk_pct = ph_snk[ph];
            cfg_we   <= 1'b1;
            cfg_data <= CFG_W'(ph_cfg[ph]);
            @(posedge clk);
            cfg_we     <= 1'b0;
            subdiv_reg  = CFG_W'(ph_cfg[ph]);
            n_settings++;
            for (int i = 0; i < ph_cnt[ph]; i++) begin
                r = $urandom_range(0, 99);
                w = rand_word(r < 8);
                if (r >= 8 && r < 28) begin
                    w.comp[COMP_Z] = last_z;
                end
                w.wait_drain = ($urandom_range(0, 99) < 3);
                push_word(w);
            end
        end

        wait_idle();
        repeat (40) @(posedge clk);
        for (int i = 0; i < exp_pts.size(); i++) begin
            report("point word never arrived, x", exp_pts[i].comp[COMP_X], 'x);
        end
        $display("%0d vertex words sent over %0d subdivision settings and three idling regimes",
                 n_taken, n_settings);
        $display("%0d curved and %0d flat segments, %0d point words checked, %0d errors",
                 n_curves, n_flats, n_points, n_errors);
        if (n_errors == 0) begin
            $display("cubic_bezier_polyline_smoother_core: match");
        end else begin
            $display("cubic_bezier_polyline_smoother_core: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
src/cbps_pkg.sv
src/cbps_if.sv
src/cbps_ctrl.sv
src/cbps_dp.sv
src/cubic_bezier_polyline_smoother_core.sv
tb/tb_top.sv
